// ===== sv/assert_macros.svh =====
// Assertion macros shared by the link address cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LAC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LAC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== sv/lac_pkg.sv =====
// Package with types, constants and codes of the link address cache.
package lac_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int LINK_BYTES_DEF = 6;

    localparam int KEY_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int LINK_IN_W  = 48;
    localparam int SLOT_W     = 3;
    localparam int STATUS_W   = 3;

    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FILLED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd4;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [KEY_W-1:0]     ip_addr;
        logic [LINK_IN_W-1:0] link_addr;
    } lac_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    slot;
        logic [LINK_IN_W-1:0] found_link;
    } lac_rsp_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit_hit;
        logic evict;
        logic miss;
    } lac_cmd_t;

    typedef struct packed {
        logic chk_vld;
        logic hit;
        logic chk_last;
        logic rd_done;
        logic insert;
    } lac_sts_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVICT
    } lac_state_t;

endpackage

// ===== sv/lac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lac_ctrl.sv =====
// Controller state machine that sequences the slot scan of each request.
module lac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lac_pkg::lac_sts_t sts,
    output lac_pkg::lac_cmd_t cmd
);

    lac_pkg::lac_state_t state_reg;
    lac_pkg::lac_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lac_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lac_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = lac_pkg::S_SCAN;
                end
            end
            lac_pkg::S_SCAN:
            begin
                cmd.issue = !sts.rd_done && !(sts.chk_vld && sts.hit);
                if (sts.chk_vld && sts.hit)
                begin
                    cmd.commit_hit = 1'b1;
                    state_next     = lac_pkg::S_IDLE;
                end
                else if (sts.chk_vld && sts.chk_last)
                begin
                    if (sts.insert)
                    begin
                        state_next = lac_pkg::S_EVICT;
                    end
                    else
                    begin
                        cmd.miss   = 1'b1;
                        state_next = lac_pkg::S_IDLE;
                    end
                end
            end
            lac_pkg::S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = lac_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lac_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != lac_pkg::S_IDLE);

endmodule

// ===== sv/lac_dp.sv =====
// Datapath: slot memory, valid bits, compare, oldest-stamp tracking and result register.
module lac_dp #(
    parameter int ENTRIES    = lac_pkg::ENTRIES_DEF,
    parameter int LINK_BYTES = lac_pkg::LINK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lac_pkg::lac_cmd_t cmd,
    output lac_pkg::lac_sts_t sts,
    input  lac_pkg::lac_req_t req,
    output logic              done,
    output lac_pkg::lac_rsp_t rsp
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINK_W = 8 * LINK_BYTES;
    localparam int ROW_W  = lac_pkg::KEY_W + LINK_W + lac_pkg::STAMP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [lac_pkg::KEY_W-1:0]   ip_reg;
    logic [LINK_W-1:0]           link_reg;
    logic                        insert_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        rd_done_reg;
    logic [IDX_W-1:0]            chk_idx_reg;
    logic                        chk_vld_reg;
    logic                        vld_q_reg;
    logic [ENTRIES-1:0]          valid_reg;
    logic [lac_pkg::STAMP_W-1:0] min_stamp_reg;
    logic [IDX_W-1:0]            min_idx_reg;
    logic [lac_pkg::STAMP_W-1:0] counter_reg;
    logic                        done_reg;
    lac_pkg::lac_rsp_t           rsp_reg;
    lac_pkg::lac_rsp_t           rsp_next;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [ROW_W-1:0]            wr_data;
    logic [ROW_W-1:0]            rd_data;
    logic [lac_pkg::KEY_W-1:0]   row_key;
    logic [LINK_W-1:0]           row_link;
    logic [lac_pkg::STAMP_W-1:0] row_stamp;
    logic [lac_pkg::STAMP_W-1:0] stamp_new;
    logic                        key_match;
    logic                        key_empty;
    logic                        hit;

    lac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.issue),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // Slots never written read as all zero.
    assign row_key   = vld_q_reg ? rd_data[ROW_W-1 -: lac_pkg::KEY_W] : '0;
    assign row_link  = vld_q_reg ? rd_data[lac_pkg::STAMP_W +: LINK_W] : '0;
    assign row_stamp = vld_q_reg ? rd_data[lac_pkg::STAMP_W-1:0] : '0;

    assign key_match = (row_key == ip_reg);
    assign key_empty = (row_key == '0);
    assign hit       = insert_reg ? (key_match || key_empty) : key_match;
    assign stamp_new = counter_reg + lac_pkg::STAMP_W'(1);

    assign wr_en   = (cmd.commit_hit && insert_reg) || cmd.evict;
    assign wr_addr = cmd.evict ? min_idx_reg : chk_idx_reg;
    assign wr_data = {ip_reg, link_reg, stamp_new};

    assign sts.chk_vld  = chk_vld_reg;
    assign sts.hit      = hit;
    assign sts.chk_last = (chk_idx_reg == LAST_IDX);
    assign sts.rd_done  = rd_done_reg;
    assign sts.insert   = insert_reg;

    always_comb
    begin
        rsp_next = '0;
        if (cmd.commit_hit)
        begin
            rsp_next.slot = lac_pkg::SLOT_W'(chk_idx_reg);
            if (insert_reg)
            begin
                rsp_next.status = key_empty ? lac_pkg::ST_FILLED : lac_pkg::ST_UPDATED;
            end
            else
            begin
                rsp_next.status     = lac_pkg::ST_HIT;
                rsp_next.found_link = lac_pkg::LINK_IN_W'(row_link);
            end
        end
        else if (cmd.evict)
        begin
            rsp_next.status = lac_pkg::ST_REPLACED;
            rsp_next.slot   = lac_pkg::SLOT_W'(min_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            rd_done_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
            vld_q_reg   <= 1'b0;
            valid_reg   <= '0;
            counter_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= cmd.issue;
            done_reg    <= cmd.commit_hit || cmd.evict || cmd.miss;
            if (cmd.load)
            begin
                rd_idx_reg  <= '0;
                rd_done_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                vld_q_reg <= valid_reg[rd_idx_reg];
                if (rd_idx_reg == LAST_IDX)
                begin
                    rd_done_reg <= 1'b1;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                counter_reg        <= stamp_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ip_reg     <= req.ip_addr;
            link_reg   <= LINK_W'(req.link_addr);
            insert_reg <= (req.action == lac_pkg::ACT_INSERT);
        end
        if (cmd.issue)
        begin
            chk_idx_reg <= rd_idx_reg;
        end
        if (chk_vld_reg && ((chk_idx_reg == '0) || (row_stamp < min_stamp_reg)))
        begin
            min_stamp_reg <= row_stamp;
            min_idx_reg   <= chk_idx_reg;
        end
        if (cmd.commit_hit || cmd.evict || cmd.miss)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/link_address_cache.sv =====
// Top level of the link address cache: controller, datapath and checks.
// A request scans the slots in order from slot 0 and ends at the first hit, when busy drops;
// a lookup miss scans every slot, and an insert that finds no match or empty slot then evicts the oldest.
// The result strobe rises at the same edge at which busy drops; the scan reads one slot per cycle.
// A new request is accepted in the cycle the previous result is shown.
// Reset clears the valid bits, so all slots and stamps read as zero, and clears the stamp counter.
module link_address_cache #(
    parameter int ENTRIES    = lac_pkg::ENTRIES_DEF,
    parameter int LINK_BYTES = lac_pkg::LINK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lac_pkg::lac_req_t req,
    output logic              done,
    output lac_pkg::lac_rsp_t rsp
);

    `include "assert_macros.svh"

    lac_pkg::lac_cmd_t cmd;
    lac_pkg::lac_sts_t sts;

    lac_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    lac_dp #(
        .ENTRIES    (ENTRIES),
        .LINK_BYTES (LINK_BYTES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    `LAC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `LAC_ASSERT_NEXT(a_single_strobe, clk, rst_n, done, !done)
    `LAC_ASSERT_IMPL(a_status_range, clk, rst_n, done, rsp.status <= lac_pkg::ST_REPLACED)
    `LAC_ASSERT_IMPL(a_insert_no_link, clk, rst_n,
        done && (rsp.status == lac_pkg::ST_MISS || rsp.status == lac_pkg::ST_UPDATED
        || rsp.status == lac_pkg::ST_FILLED || rsp.status == lac_pkg::ST_REPLACED),
        rsp.found_link == '0)

endmodule
